>>> rtl/ste_pkg.sv
package ste_pkg;

   localparam int TILE_SIZE_DEFAULT = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_FLIP_SCREEN   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 2'd2;

   localparam logic [10:0] SCREEN_WIDTH_RESET  = 11'd320;
   localparam logic [10:0] SCREEN_HEIGHT_RESET = 11'd240;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_ROW  = 1'b1;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EMIT
   } ste_state_type;

   typedef struct packed {
      logic load;
      logic start_row;
      logic emit;
   } ste_cmd_type;

   typedef struct packed {
      logic active;
      logic last_col;
      logic slot_free;
   } ste_status_type;

endpackage

>>> rtl/sprite_tile_expander_unit.sv
// Sprite tile expander.
// A request with kind 0 loads a sprite from its four attribute words and
// produces no response; a hidden sprite just clears the active sprite.
// A request with kind 1 expands the next tile row of the active sprite into
// one response per tile, in drawing order, with row_end and sprite_end marks.
// A row request on an idle block produces nothing.
// A row request first sets the column to zero; the row then moves one tile
// per cycle, while the receiver does not stall, from the position and scale
// datapath into the response register. The block takes no new request while
// a row is being expanded.
// When the receiver stalls, the response register holds its tile and the
// row pauses until that tile is taken; a load may be accepted while the
// last tile of a row still waits.
// Reset clears the active sprite and the response valid flag and sets the
// screen registers to no flip, 320 by 240. Write the csr registers only
// while no row is in progress.
module sprite_tile_expander_unit
   import ste_pkg::*;
#(
   parameter int TILE_SIZE = TILE_SIZE_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic [15:0]            req_x_word,
   input  logic [15:0]            req_y_word,
   input  logic [15:0]            req_attr_word,
   input  logic [15:0]            req_code_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [15:0]            rsp_tile_code,
   output logic [5:0]             rsp_color,
   output logic                   rsp_flip_x_out,
   output logic                   rsp_flip_y_out,
   output logic signed [11:0]     rsp_pos_x,
   output logic signed [11:0]     rsp_pos_y,
   output logic [16:0]            rsp_scale_x,
   output logic [16:0]            rsp_scale_y,
   output logic                   rsp_zoomed,
   output logic [7:0]             rsp_priority_mask,
   output logic                   rsp_row_end,
   output logic                   rsp_sprite_end
);

   ste_cmd_type    cmd;
   ste_status_type status;

   ste_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ste_datapath #(
      .TILE_SIZE (TILE_SIZE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_x_word        (req_x_word),
      .req_y_word        (req_y_word),
      .req_attr_word     (req_attr_word),
      .req_code_word     (req_code_word),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tile_code     (rsp_tile_code),
      .rsp_color         (rsp_color),
      .rsp_flip_x_out    (rsp_flip_x_out),
      .rsp_flip_y_out    (rsp_flip_y_out),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_scale_x       (rsp_scale_x),
      .rsp_scale_y       (rsp_scale_y),
      .rsp_zoomed        (rsp_zoomed),
      .rsp_priority_mask (rsp_priority_mask),
      .rsp_row_end       (rsp_row_end),
      .rsp_sprite_end    (rsp_sprite_end)
   );

endmodule

>>> rtl/ste_ctrl.sv
module ste_ctrl
   import ste_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_kind,
   output logic           req_stall,
   input  ste_status_type status,
   output ste_cmd_type    cmd
);

   ste_state_type state_ff;
   ste_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_kind == KIND_ROW) && status.active) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.slot_free && status.last_col) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            cmd.load      = req_valid && (req_kind == KIND_LOAD);
            cmd.start_row = req_valid && (req_kind == KIND_ROW) && status.active;
         end
         ST_EMIT: begin
            cmd.emit = status.slot_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

>>> rtl/ste_datapath.sv
module ste_datapath
   import ste_pkg::*;
#(
   parameter int TILE_SIZE = TILE_SIZE_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [15:0]            req_x_word,
   input  logic [15:0]            req_y_word,
   input  logic [15:0]            req_attr_word,
   input  logic [15:0]            req_code_word,
   input  ste_cmd_type            cmd,
   output ste_status_type         status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [15:0]            rsp_tile_code,
   output logic [5:0]             rsp_color,
   output logic                   rsp_flip_x_out,
   output logic                   rsp_flip_y_out,
   output logic signed [11:0]     rsp_pos_x,
   output logic signed [11:0]     rsp_pos_y,
   output logic [16:0]            rsp_scale_x,
   output logic [16:0]            rsp_scale_y,
   output logic                   rsp_zoomed,
   output logic [7:0]             rsp_priority_mask,
   output logic                   rsp_row_end,
   output logic                   rsp_sprite_end
);

   localparam int STEP_FULL  = TILE_SIZE * 8;
   localparam int STEP_W     = $clog2(STEP_FULL + 1);
   localparam int PROD_W     = STEP_W + 4;
   localparam int SCALE_UNIT = 65536 / TILE_SIZE / 8;
   localparam int SC_RAW_W   = $clog2(SCALE_UNIT * (STEP_FULL + 8) + 1);
   localparam int SC_W       = (SC_RAW_W > 17) ? SC_RAW_W : 17;

   localparam logic [7:0] MASK_PRI0 = 8'h00;
   localparam logic [7:0] MASK_PRI1 = 8'hf0;
   localparam logic [7:0] MASK_PRI2 = 8'hf0 | 8'hcc;
   localparam logic [7:0] MASK_PRI3 = 8'hf0 | 8'hcc | 8'haa;
   localparam logic [16:0] SCALE_MAX = 17'h1ffff;

   logic        flip_screen_ff, flip_screen_in;
   logic [10:0] screen_width_ff, screen_width_in;
   logic [10:0] screen_height_ff, screen_height_in;

   logic        active_ff, active_in;
   logic [15:0] next_code_ff, next_code_in;
   logic [3:0]  row_ff, row_in;
   logic [3:0]  col_ff, col_in;
   logic [11:0] base_x_ff, base_x_in;
   logic [11:0] base_y_ff, base_y_in;
   logic [3:0]  count_x_ff, count_x_in;
   logic [3:0]  count_y_ff, count_y_in;
   logic        mirror_x_ff, mirror_x_in;
   logic        mirror_y_ff, mirror_y_in;
   logic [3:0]  zoom_x_ff, zoom_x_in;
   logic [3:0]  zoom_y_ff, zoom_y_in;
   logic [5:0]  palette_ff, palette_in;
   logic [7:0]  layer_mask_ff, layer_mask_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] out_code_ff;
   logic [5:0]  out_color_ff;
   logic        out_flip_x_ff;
   logic        out_flip_y_ff;
   logic [11:0] out_pos_x_ff;
   logic [11:0] out_pos_y_ff;
   logic [16:0] out_scale_x_ff;
   logic [16:0] out_scale_y_ff;
   logic        out_zoomed_ff;
   logic [7:0]  out_mask_ff;
   logic        out_row_end_ff;
   logic        out_sprite_end_ff;

   logic [4:0]  tiles_x_new;
   logic [4:0]  tiles_y_new;
   logic [11:0] sx_ext;
   logic [11:0] sy_ext;
   logic [11:0] sx_load;
   logic [11:0] sy_load;
   logic [7:0]  mask_new;

   logic [STEP_W-1:0] step_x;
   logic [STEP_W-1:0] step_y;
   logic [3:0]        xi;
   logic [3:0]        yi;
   logic [PROD_W-1:0] prod_x;
   logic [PROD_W-1:0] prod_y;
   logic [11:0]       tile_pos_x;
   logic [11:0]       tile_pos_y;
   logic [SC_W-1:0]   scale_raw_x;
   logic [SC_W-1:0]   scale_raw_y;
   logic [16:0]       tile_scale_x;
   logic [16:0]       tile_scale_y;
   logic              last_col;
   logic              last_row;
   logic              slot_free;

   // Sprite decode at load time.
   always_comb begin
      tiles_x_new = {1'b0, req_x_word[15:12]} + 5'd1;
      tiles_y_new = {1'b0, req_y_word[15:12]} + 5'd1;
      sx_ext      = {{2{req_x_word[9]}}, req_x_word[9:0]};
      sy_ext      = {{2{req_y_word[9]}}, req_y_word[9:0]};
      if (flip_screen_ff) begin
         sx_load = {1'b0, screen_width_ff} - sx_ext - 12'(tiles_x_new * TILE_SIZE);
         sy_load = {1'b0, screen_height_ff} - sy_ext - 12'(tiles_y_new * TILE_SIZE);
      end else begin
         sx_load = sx_ext;
         sy_load = sy_ext;
      end
      case (req_attr_word[7:6])
         2'd1:    mask_new = MASK_PRI1;
         2'd2:    mask_new = MASK_PRI2;
         2'd3:    mask_new = MASK_PRI3;
         default: mask_new = MASK_PRI0;
      endcase
   end

   // Tile geometry for the current column and row.
   always_comb begin
      step_x       = STEP_W'(STEP_FULL) - STEP_W'({zoom_x_ff, 2'b00});
      step_y       = STEP_W'(STEP_FULL) - STEP_W'({zoom_y_ff, 2'b00});
      xi           = mirror_x_ff ? (count_x_ff - col_ff) : col_ff;
      yi           = mirror_y_ff ? (count_y_ff - row_ff) : row_ff;
      prod_x       = PROD_W'(xi) * PROD_W'(step_x);
      prod_y       = PROD_W'(yi) * PROD_W'(step_y);
      tile_pos_x   = base_x_ff + 12'(prod_x[PROD_W-1:3]);
      tile_pos_y   = base_y_ff + 12'(prod_y[PROD_W-1:3]);
      scale_raw_x  = SC_W'(SCALE_UNIT) * (SC_W'(step_x) + SC_W'(8));
      scale_raw_y  = SC_W'(SCALE_UNIT) * (SC_W'(step_y) + SC_W'(8));
      tile_scale_x = (scale_raw_x > SC_W'(SCALE_MAX)) ? SCALE_MAX : 17'(scale_raw_x);
      tile_scale_y = (scale_raw_y > SC_W'(SCALE_MAX)) ? SCALE_MAX : 17'(scale_raw_y);
      last_col     = (col_ff == count_x_ff);
      last_row     = (row_ff == count_y_ff);
      slot_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      flip_screen_in   = flip_screen_ff;
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FLIP_SCREEN:   flip_screen_in   = csr_wdata[0];
            CSR_SCREEN_WIDTH:  screen_width_in  = csr_wdata;
            CSR_SCREEN_HEIGHT: screen_height_in = csr_wdata;
            default: begin
               flip_screen_in = flip_screen_ff;
            end
         endcase
      end
   end

   always_comb begin
      active_in     = active_ff;
      next_code_in  = next_code_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      base_x_in     = base_x_ff;
      base_y_in     = base_y_ff;
      count_x_in    = count_x_ff;
      count_y_in    = count_y_ff;
      mirror_x_in   = mirror_x_ff;
      mirror_y_in   = mirror_y_ff;
      zoom_x_in     = zoom_x_ff;
      zoom_y_in     = zoom_y_ff;
      palette_in    = palette_ff;
      layer_mask_in = layer_mask_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         if (req_x_word[10]) begin
            active_in = 1'b0;
         end else begin
            active_in     = 1'b1;
            count_x_in    = req_x_word[15:12];
            count_y_in    = req_y_word[15:12];
            mirror_x_in   = req_x_word[11] ^ flip_screen_ff;
            mirror_y_in   = req_y_word[11] ^ flip_screen_ff;
            zoom_x_in     = req_attr_word[15:12];
            zoom_y_in     = req_attr_word[11:8];
            palette_in    = req_attr_word[5:0];
            layer_mask_in = mask_new;
            base_x_in     = sx_load;
            base_y_in     = sy_load;
            next_code_in  = req_code_word;
            row_in        = 4'd0;
         end
      end

      if (cmd.start_row) begin
         col_in = 4'd0;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         next_code_in = next_code_ff + 16'd1;
         col_in       = col_ff + 4'd1;
         if (last_col) begin
            row_in = row_ff + 4'd1;
            if (last_row) begin
               active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_screen_ff   <= 1'b0;
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
         active_ff        <= 1'b0;
         row_ff           <= 4'd0;
         col_ff           <= 4'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         flip_screen_ff   <= flip_screen_in;
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
         active_ff        <= active_in;
         row_ff           <= row_in;
         col_ff           <= col_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      next_code_ff  <= next_code_in;
      base_x_ff     <= base_x_in;
      base_y_ff     <= base_y_in;
      count_x_ff    <= count_x_in;
      count_y_ff    <= count_y_in;
      mirror_x_ff   <= mirror_x_in;
      mirror_y_ff   <= mirror_y_in;
      zoom_x_ff     <= zoom_x_in;
      zoom_y_ff     <= zoom_y_in;
      palette_ff    <= palette_in;
      layer_mask_ff <= layer_mask_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_code_ff       <= next_code_ff;
         out_color_ff      <= palette_ff;
         out_flip_x_ff     <= mirror_x_ff;
         out_flip_y_ff     <= mirror_y_ff;
         out_pos_x_ff      <= tile_pos_x;
         out_pos_y_ff      <= tile_pos_y;
         out_scale_x_ff    <= tile_scale_x;
         out_scale_y_ff    <= tile_scale_y;
         out_zoomed_ff     <= (zoom_x_ff != 4'd0) || (zoom_y_ff != 4'd0);
         out_mask_ff       <= layer_mask_ff;
         out_row_end_ff    <= last_col;
         out_sprite_end_ff <= last_col && last_row;
      end
   end

   assign status.active    = active_ff;
   assign status.last_col  = last_col;
   assign status.slot_free = slot_free;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tile_code     = out_code_ff;
   assign rsp_color         = out_color_ff;
   assign rsp_flip_x_out    = out_flip_x_ff;
   assign rsp_flip_y_out    = out_flip_y_ff;
   assign rsp_pos_x         = $signed(out_pos_x_ff);
   assign rsp_pos_y         = $signed(out_pos_y_ff);
   assign rsp_scale_x       = out_scale_x_ff;
   assign rsp_scale_y       = out_scale_y_ff;
   assign rsp_zoomed        = out_zoomed_ff;
   assign rsp_priority_mask = out_mask_ff;
   assign rsp_row_end       = out_row_end_ff;
   assign rsp_sprite_end    = out_sprite_end_ff;

endmodule
